/* rtl/msnm_pkg.sv */
// shared types and constants for the sine note mixer
// fixed field widths, register indexes, reset values and the base frequency table
// no dependencies
package msnm_pkg;

   localparam int MIX_WIDTH  = 16;
   localparam int AMP_WIDTH  = 16;
   localparam int NOTE_WIDTH = 7;
   localparam int SINE_WIDTH = 15;
   localparam int TONE_WIDTH = 17;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NOTE_NUMBER = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AMPLITUDE   = 1'b1;

   localparam logic [NOTE_WIDTH-1:0] NOTE_RESET = 7'd69;
   localparam logic [AMP_WIDTH-1:0]  AMP_RESET  = 16'h8000;

   // pi/2 in Q30
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // notes 0..11 in Hz, Q24, rounded to nearest
   localparam longint unsigned BASE_FREQ_Q24 [12] = '{
      64'd137167144, 64'd145323527, 64'd153964914, 64'd163120144,
      64'd172819773, 64'd183096171, 64'd193983636, 64'd205518503,
      64'd217739269, 64'd230686720, 64'd244404066, 64'd258937088
   };

   typedef struct packed {
      logic                        valid;
      logic                        gate;
      logic                        negate;
      logic signed [MIX_WIDTH-1:0] mix;
   } stage_ctl_type;

endpackage

/* rtl/msnm_phase_gen.sv */
// phase accumulator with note increment register and quarter-wave address mapping
// increment table built at elaboration from the base frequency table
// depends on msnm_pkg
module msnm_phase_gen import msnm_pkg::*; #(
   parameter int SAMPLE_RATE = 44100,
   parameter int PHASE_BITS  = 32,
   parameter int TABLE_BITS  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  note_we,
   input  logic [NOTE_WIDTH-1:0] note_value,
   input  logic                  accept,
   input  logic                  gate,
   input  logic                  note_start,
   output logic [TABLE_BITS-2:0] rom_addr,
   output logic                  negate
);

   localparam int QuarterLen = 1 << (TABLE_BITS - 2);
   localparam int AddrWidth  = TABLE_BITS - 1;
   localparam int IncShift   = (PHASE_BITS >= 24) ? PHASE_BITS - 24 : 0;
   localparam longint unsigned IncDen = (PHASE_BITS >= 24) ?
      longint'(SAMPLE_RATE) : (longint'(SAMPLE_RATE) << (24 - PHASE_BITS));

   typedef logic [PHASE_BITS-1:0] inc_tab_type [128];

   function automatic inc_tab_type build_inc();
      inc_tab_type     tab;
      longint unsigned num;
      for (int n = 0; n < 128; n++) begin
         num    = (BASE_FREQ_Q24[n % 12] << (n / 12)) << IncShift;
         tab[n] = PHASE_BITS'((num + IncDen / 2) / IncDen);
      end
      return tab;
   endfunction

   localparam inc_tab_type INC_TABLE = build_inc();

   logic [PHASE_BITS-1:0] inc_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] phase_base;
   logic [TABLE_BITS-1:0] idx;
   logic [TABLE_BITS-3:0] pos;

   // note start clears the phase ahead of this word
   assign phase_base = note_start ? '0 : phase_ff;
   assign phase_in   = gate ? phase_base + inc_ff : phase_base;

   assign idx    = phase_base[PHASE_BITS-1 -: TABLE_BITS];
   assign pos    = idx[TABLE_BITS-3:0];
   assign negate = idx[TABLE_BITS-1];
   // odd quadrants read the table backwards
   assign rom_addr = idx[TABLE_BITS-2] ? AddrWidth'(QuarterLen) - {1'b0, pos}
                                       : {1'b0, pos};

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff   <= INC_TABLE[NOTE_RESET];
         phase_ff <= '0;
      end else begin
         if (note_we) begin
            inc_ff <= INC_TABLE[note_value];
         end
         if (accept) begin
            phase_ff <= phase_in;
         end
      end
   end

endmodule

/* rtl/msnm_sine_rom.sv */
// quarter-wave sine rom, round(32767 * sin(x)) on [0, pi/2], registered read
// contents from a Q30 taylor sum evaluated at elaboration
// depends on msnm_pkg
module msnm_sine_rom import msnm_pkg::*; #(
   parameter int TABLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [TABLE_BITS-2:0] addr,
   output logic [SINE_WIDTH-1:0] data
);

   localparam int QuarterLen = 1 << (TABLE_BITS - 2);

   typedef logic [SINE_WIDTH-1:0] rom_type [QuarterLen+1];

   function automatic rom_type build_rom();
      rom_type         tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          v;
      for (int k = 0; k <= QuarterLen; k++) begin
         x    = (longint'(k) * HALF_PI_Q30 + QuarterLen / 2) / QuarterLen;
         x2   = (x * x) >> 30;
         sum  = longint'(x);
         term = ((x * x2) >> 30) / 6;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 20;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 42;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 72;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 110;
         sum  = sum - longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         v = longint'((longint'(sum) * 32767 + (64'd1 << 29)) >> 30);
         if (v > 32767) begin
            v = 32767;
         end
         tab[k] = SINE_WIDTH'(v);
      end
      return tab;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [SINE_WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= SINE_ROM[addr];
      end
   end

   assign data = data_ff;

endmodule

/* rtl/msnm_tone.sv */
// gain multiply with rounding, then signed add into the mix word with saturation
// holds the product stage register
// depends on msnm_pkg
module msnm_tone import msnm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  stage_ctl_type               ctl1,
   input  logic [SINE_WIDTH-1:0]       sine,
   input  logic [AMP_WIDTH-1:0]        amplitude,
   output stage_ctl_type               ctl2,
   output logic signed [MIX_WIDTH-1:0] mix_sat
);

   localparam int ProdWidth = AMP_WIDTH + SINE_WIDTH + 1;
   localparam int SumWidth  = TONE_WIDTH + 2;

   stage_ctl_type           ctl2_ff;
   logic [TONE_WIDTH-1:0]   tone_ff;
   logic [TONE_WIDTH-1:0]   tone_in;
   logic [ProdWidth-1:0]    prod;
   logic signed [TONE_WIDTH:0] tone_signed;
   logic signed [SumWidth-1:0] sum;

   // magnitude times gain, half up then drop 15 fraction bits
   assign prod    = ProdWidth'(amplitude) * ProdWidth'(sine) + ProdWidth'(16384);
   assign tone_in = prod[ProdWidth-1 -: TONE_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl2_ff.valid <= ctl1.valid;
      end
      if (advance) begin
         ctl2_ff.gate   <= ctl1.gate;
         ctl2_ff.negate <= ctl1.negate;
         ctl2_ff.mix    <= ctl1.mix;
         tone_ff        <= tone_in;
      end
   end

   assign tone_signed = ctl2_ff.negate ? -$signed({1'b0, tone_ff}) : $signed({1'b0, tone_ff});
   assign sum = SumWidth'(ctl2_ff.mix) + SumWidth'(tone_signed);

   always_comb begin
      if (!ctl2_ff.gate) begin
         mix_sat = ctl2_ff.mix;
      end else if (sum > SumWidth'(32767)) begin
         mix_sat = 16'sh7fff;
      end else if (sum < -SumWidth'(32768)) begin
         mix_sat = -16'sh8000;
      end else begin
         mix_sat = sum[MIX_WIDTH-1:0];
      end
   end

   assign ctl2 = ctl2_ff;

endmodule

/* rtl/midi_sine_note_mixer_core.sv */
// sine note mixer: adds a gated sine tone at the programmed note into a sample stream
// from req word accepted to rsp_tvalid: rom read, gain multiply, saturating add,
// each one register; throughput one word per cycle without backpressure
// reset clears the phase and pipeline valids and sets note 69 and unity gain;
// the increment and sine tables are constant, so no clearing pass is needed
module midi_sine_note_mixer_core import msnm_pkg::*; #(
   parameter int SAMPLE_RATE = 44100,
   parameter int PHASE_BITS  = 32,
   parameter int TABLE_BITS  = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [15:0]                req_tdata,   // [15:0] mix_in
   input  logic [1:0]                 req_tuser,   // [0] gate, [1] note_start
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // [15:0] mix_out
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [AMP_WIDTH-1:0]       csr_wdata
);

   logic                        advance;
   logic                        accept;
   logic [TABLE_BITS-2:0]       rom_addr;
   logic                        negate;
   logic [SINE_WIDTH-1:0]       sine;
   logic [AMP_WIDTH-1:0]        amplitude_ff;
   stage_ctl_type               ctl1_ff;
   stage_ctl_type               ctl2;
   logic signed [MIX_WIDTH-1:0] mix_sat;
   logic                        rsp_valid_ff;
   logic [MIX_WIDTH-1:0]        rsp_data_ff;

   // whole pipe moves whenever the output register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && advance;
   assign req_tready = advance;

   msnm_phase_gen #(
      .SAMPLE_RATE (SAMPLE_RATE),
      .PHASE_BITS  (PHASE_BITS),
      .TABLE_BITS  (TABLE_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .note_we    (csr_we && (csr_index == CSR_NOTE_NUMBER)),
      .note_value (csr_wdata[NOTE_WIDTH-1:0]),
      .accept     (accept),
      .gate       (req_tuser[0]),
      .note_start (req_tuser[1]),
      .rom_addr   (rom_addr),
      .negate     (negate)
   );

   msnm_sine_rom #(
      .TABLE_BITS (TABLE_BITS)
   ) u_rom (
      .clock (clock),
      .rd_en (advance),
      .addr  (rom_addr),
      .data  (sine)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff <= AMP_RESET;
      end else if (csr_we && (csr_index == CSR_AMPLITUDE)) begin
         amplitude_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl1_ff.valid <= accept;
      end
      if (advance) begin
         ctl1_ff.gate   <= req_tuser[0];
         ctl1_ff.negate <= negate;
         ctl1_ff.mix    <= $signed(req_tdata);
      end
   end

   msnm_tone u_tone (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl1      (ctl1_ff),
      .sine      (sine),
      .amplitude (amplitude_ff),
      .ctl2      (ctl2),
      .mix_sat   (mix_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctl2.valid;
      end
      if (advance) begin
         rsp_data_ff <= mix_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_reset_empties_pipe : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !ctl1_ff.valid && !ctl2.valid)
      else $error("pipeline valid left set by reset");

   a_gate_low_passes : assert property (@(posedge clock) disable iff (reset)
      advance && ctl2.valid && !ctl2.gate |=> rsp_tdata == $past(ctl2.mix))
      else $error("gated-off word not passed through unchanged");

   a_positive_tone_no_drop : assert property (@(posedge clock) disable iff (reset)
      ctl2.valid && ctl2.gate && !ctl2.negate |-> mix_sat >= ctl2.mix)
      else $error("positive tone lowered the mix word");

endmodule

/* bench/note_mixer_monitor.sv */
// stream monitor for the sine note mixer: tracks register writes, predicts each mix_out word
// from its own oscillator model and compares it with what the block sends back
// depends on msnm_pkg for the register index width and codes
module note_mixer_monitor import msnm_pkg::*; #(
   parameter int SAMPLE_RATE = 44100,
   parameter int PHASE_BITS  = 32,
   parameter int TABLE_BITS  = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   input  logic [15:0]                req_tdata,   // [15:0] mix_in
   input  logic [1:0]                 req_tuser,   // [0] gate, [1] note_start
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic [15:0]                rsp_tdata,   // [15:0] mix_out
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [AMP_WIDTH-1:0]       csr_wdata,
   output int                         mismatch_count,
   output int                         outstanding
);

   localparam int QUARTER = 1 << (TABLE_BITS - 2);
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   // octave-zero notes in Hz, Q24
   localparam longint unsigned NOTE_HZ_Q24 [12] = '{
      64'd137167144, 64'd145323527, 64'd153964914, 64'd163120144,
      64'd172819773, 64'd183096171, 64'd193983636, 64'd205518503,
      64'd217739269, 64'd230686720, 64'd244404066, 64'd258937088
   };

   int                    sine_rom [0:QUARTER];
   logic [PHASE_BITS-1:0] phase;
   logic [6:0]            note;
   logic [15:0]           gain;
   logic signed [15:0]    mixed_samples_due [$];
   logic signed [15:0]    due_mix;
   logic signed [15:0]    next_mix;
   int                    errors = 0;

   initial begin
      longint unsigned x, x2, term;
      longint signed   acc, v;
      // quarter-wave rom, taylor series through x^11 in Q30
      for (int k = 0; k <= QUARTER; k++) begin
         x    = (k * PI_HALF_Q30 + QUARTER / 2) / QUARTER;
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) acc = 0;
         v = (acc * 32767 + 64'sd536870912) >>> 30;
         if (v > 32767) v = 32767;
         sine_rom[k] = int'(v);
      end
   end

   function automatic longint unsigned step_for_note(input logic [6:0] n);
      longint unsigned num, den;
      num = NOTE_HZ_Q24[n % 12] << (n / 12);
      den = SAMPLE_RATE;
      if (PHASE_BITS >= 24) begin
         num = num << (PHASE_BITS - 24);
      end else begin
         den = den << (24 - PHASE_BITS);
      end
      return (num + den / 2) / den;
   endfunction

   function automatic int sine_of(input logic [PHASE_BITS-1:0] ph);
      logic [TABLE_BITS-1:0] idx;
      logic [1:0]            quad;
      int                    pos, v;
      idx  = ph[PHASE_BITS-1 -: TABLE_BITS];
      quad = idx[TABLE_BITS-1 -: 2];
      pos  = int'(idx[TABLE_BITS-3:0]);
      v    = quad[0] ? sine_rom[QUARTER - pos] : sine_rom[pos];
      return quad[1] ? -v : v;
   endfunction

   // advances the oscillator state as a side effect
   function automatic logic signed [15:0] mix_in_tone(input logic signed [15:0] mix,
                                                      input logic gate, input logic start);
      longint signed   sum;
      int              s;
      longint unsigned mag, t;
      sum = longint'(mix);
      if (start) phase = '0;
      if (gate) begin
         s   = sine_of(phase);
         mag = longint'((s < 0) ? -s : s);
         t   = (gain * mag + 16384) >> 15;
         sum = (s < 0) ? mix - longint'(t) : mix + longint'(t);
         if (sum > 32767) sum = 32767;
         if (sum < -32768) sum = -32768;
         phase = phase + PHASE_BITS'(step_for_note(note));
      end
      return sum[15:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase = '0;
         note  = 7'd69;
         gain  = 16'd32768;
         mixed_samples_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NOTE_NUMBER: note = csr_wdata[6:0];
               CSR_AMPLITUDE:   gain = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            next_mix = mix_in_tone(req_tdata, req_tuser[0], req_tuser[1]);
            mixed_samples_due = {mixed_samples_due, next_mix};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (mixed_samples_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected mix_out word, expected none, got %0d",
                        $time, $signed(rsp_tdata));
            end else begin
               due_mix = mixed_samples_due.pop_front();
               if (rsp_tdata !== due_mix) begin
                  errors++;
                  $display("%0t: mix_out mismatch, expected %0d, got %0d",
                           $time, due_mix, $signed(rsp_tdata));
               end
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= mixed_samples_due.size();
   end

endmodule

/* bench/tb.sv */
// top of the sine note mixer bench: clock, reset, register programming, sample stimulus
// with random gaps and back-pressure, watchdog and verdict
// depends on msnm_pkg, midi_sine_note_mixer_core and note_mixer_monitor
module tb;
   import msnm_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [15:0]                req_tdata = '0;   // [15:0] mix_in
   logic [1:0]                 req_tuser = '0;   // [0] gate, [1] note_start
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [15:0]                rsp_tdata;        // [15:0] mix_out
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_NOTE_NUMBER;
   logic [AMP_WIDTH-1:0]       csr_wdata = '0;

   int mismatch_count;
   int outstanding;
   int stalled_cycles = 0;
   bit steady_sender = 1'b0;

   always #5 clock = ~clock;

   midi_sine_note_mixer_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   note_mixer_monitor monitor (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count), .outstanding(outstanding)
   );

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver: random gaps, steady stretches with no gaps, and one long hold-off to fill the pipe
   initial begin
      int gap;
      int taken;
      bit steady;
      taken  = 0;
      steady = 1'b0;
      @(posedge clock);
      forever begin
         if (taken % 32 == 0) steady = ($urandom_range(0, 2) == 0);
         gap = steady ? 0 : $urandom_range(0, 19);
         if (taken == 400) gap = 600;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   task automatic send_word(input logic [15:0] mix, input logic gate, input logic start);
      int gap;
      gap = steady_sender ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= mix;
      req_tuser  <= {start, gate};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic program_tone(input logic [6:0] note, input logic [15:0] amp);
      csr_we    <= 1'b1;
      csr_index <= CSR_NOTE_NUMBER;
      csr_wdata <= {9'd0, note};
      @(posedge clock);
      csr_index <= CSR_AMPLITUDE;
      csr_wdata <= amp;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // notes: a start word opening a gated run, mostly well formed, some pure noise
   task automatic play_notes(input int count);
      int          left, run, sel;
      bit          noisy;
      logic [15:0] m;
      logic        g, s;
      left = count;
      while (left > 0) begin
         run = $urandom_range(4, 60);
         if (run > left) run = left;
         noisy = ($urandom_range(0, 9) == 0);
         steady_sender = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < run; i++) begin
            sel = $urandom_range(0, 7);
            m = (sel == 0) ? 16'h7fff : (sel == 1) ? 16'h8000 : 16'($urandom);
            if (noisy) begin
               g = 1'($urandom_range(0, 1));
               s = 1'($urandom_range(0, 1));
            end else begin
               s = (i == 0) || ($urandom_range(0, 39) == 0);
               g = (i == 0) || ($urandom_range(0, 9) != 0);
            end
            send_word(m, g, s);
         end
         left -= run;
      end
   endtask

   initial begin
      logic [6:0]  note;
      logic [15:0] amp;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset setting
      send_word(16'h0000, 1'b0, 1'b0);
      send_word(16'h7fff, 1'b0, 1'b0);
      send_word(16'h8000, 1'b0, 1'b0);
      send_word(16'hffff, 1'b0, 1'b1);   // start with gate low: phase clears, word passes
      send_word(16'h7fff, 1'b1, 1'b1);
      repeat (10) send_word(16'h7fff, 1'b1, 1'b0);   // positive saturation
      send_word(16'd12345, 1'b0, 1'b0);   // phase holds
      repeat (4) send_word(16'h8000, 1'b1, 1'b0);
      send_word(16'h0000, 1'b1, 1'b1);
      repeat (4) send_word(16'($urandom), 1'b1, 1'b0);
      settle();

      for (int p = 0; p < 9; p++) begin
         case (p)
            0: begin note = 7'd0;   amp = 16'd0;     end
            1: begin note = 7'd127; amp = 16'hffff;  end
            2: begin note = 7'd127; amp = 16'd32768; end
            3: begin note = 7'd0;   amp = 16'hffff;  end
            4: begin note = 7'd60;  amp = 16'd32768; end
            default: begin
               note = 7'($urandom_range(0, 127));
               amp  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
                                                  : 16'($urandom_range(30000, 32768));
            end
         endcase
         program_tone(note, amp);
         play_notes(145);
         settle();
      end

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
